// ===== rtl/core/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the BGGR bilinear demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int PIX_W   = 8;     // raw and colour sample width
   localparam int DIM_W   = 13;    // width/height register width
   localparam int POS_W   = 12;    // row/column index width on the result
   localparam int ADDR_W  = 3;     // byte address of the register file
   localparam int DATA_W  = 32;

   localparam logic [DIM_W-1:0] DIM_MIN        = 13'd3;
   localparam logic [DIM_W-1:0] HEIGHT_MAX     = 13'd4096;
   localparam logic [DIM_W-1:0] WIDTH_RESET    = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET   = 13'd480;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // 3x3 strip minus the newest column: [0..2] column c-2, [3..5] column c-1,
   // each top, middle, bottom
   typedef logic [5:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic odd_row;
      logic odd_col;
   } site_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             restart;   // any register write restarts the frame
   } cfg_type;

endpackage

// ===== rtl/core/bayer_bggr_bilinear_demosaic_top.sv =====
// ----------------------------------------------------------------------------
// bayer_bggr_bilinear_demosaic_top
// Streaming BGGR Bayer to RGB888 bilinear demosaic.
// ----------------------------------------------------------------------------
// Takes one 8-bit raw sample per cycle in raster order (row 0 starts B G) and
// returns RGB888 for every interior pixel, tagged with its row and column and
// a frame_last flag on the last interior pixel of the frame. The result for
// pixel (r, c) is produced by the transfer of sample (r+1, c+1); border pixels
// give nothing. Throughput is one sample per cycle while rsp_stall is low. From
// the input transfer to rsp_valid a sample passes the line store read
// (a single dual-port RAM of MAX_WIDTH x 16 bits holding the two previous
// lines) and then the interpolation into the output register. The output
// register lets a new sample in while a result waits; req_stall rises only
// while a result is held on rsp_stall and the sample behind it also has one.
// The line stores need no clearing: entries are only read unwritten in rows 0
// and 1 of a frame, which never yield a result. Width is clamped to
// 3..MAX_WIDTH and height to 3..4096. Any register write restarts the frame at
// row 0, column 0; write registers only when the block is idle.
// ----------------------------------------------------------------------------
module bayer_bggr_bilinear_demosaic_top
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // raw sample channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_raw_pixel,
   // RGB result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_red,
   output logic [PIX_W-1:0]  rsp_green,
   output logic [PIX_W-1:0]  rsp_blue,
   output logic [POS_W-1:0]  rsp_out_row,
   output logic [POS_W-1:0]  rsp_out_col,
   output logic              rsp_frame_last,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);          // column counter / RAM address
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int SW = (WB > DIM_W) ? WB : DIM_W;  // clamped width

   cfg_type cfg;

   bbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // clamped frame size
   logic [SW-1:0]    width_sat, width_ext;
   logic [DIM_W-1:0] height_sat;

   assign width_ext = SW'(cfg.width);

   always_comb begin
      priority if (width_ext < SW'(DIM_MIN))    width_sat = SW'(DIM_MIN);
      else if (width_ext > SW'(MAX_WIDTH))      width_sat = SW'(MAX_WIDTH);
      else                                      width_sat = width_ext;
   end

   always_comb begin
      priority if (cfg.height < DIM_MIN)        height_sat = DIM_MIN;
      else if (cfg.height > HEIGHT_MAX)         height_sat = HEIGHT_MAX;
      else                                      height_sat = cfg.height;
   end

   // handshakes
   logic accept, s1_go, out_load;
   logic s1_valid_ff, s1_valid_in;
   logic s1_emit_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_go     = s1_valid_ff & (~s1_emit_ff | ~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_go;
   assign accept    = req_valid & ~req_stall;
   assign out_load  = s1_go & s1_emit_ff;

   // position of the next sample
   logic [CW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic             col_last, row_last;

   assign col_last = (SW'(col_ff) + SW'(1)) >= width_sat;
   assign row_last = (DIM_W'(row_ff) + DIM_W'(1)) >= height_sat;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store data back, interpolate, write back
   logic [CW-1:0]    s1_col_ff;
   pixel_type        s1_pix_ff;
   logic             s1_last_ff;
   logic [POS_W-1:0] s1_orow_ff, s1_ocol_ff;
   site_type         s1_site_ff;

   assign s1_valid_in = accept | (s1_valid_ff & ~s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff          <= col_ff;
         s1_pix_ff          <= req_raw_pixel;
         s1_emit_ff         <= (row_ff >= POS_W'(2)) && (col_ff >= CW'(2));
         s1_last_ff         <= row_last & col_last;
         s1_orow_ff         <= row_ff - POS_W'(1);
         s1_ocol_ff         <= POS_W'(col_ff) - POS_W'(1);
         s1_site_ff.odd_row <= ~row_ff[0];
         s1_site_ff.odd_col <= ~col_ff[0];
      end
   end

   // Same column recurs only every width >= 3 samples, so a read never
   // meets a pending write to its own entry.
   logic [2*PIX_W-1:0] rd_data;
   pixel_type          top, mid;

   bbd_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_pix_ff})
   );

   assign top = rd_data[2*PIX_W-1:PIX_W];
   assign mid = rd_data[PIX_W-1:0];

   // window of the two previous columns
   window_type win_ff, win_in;

   assign win_in = {s1_pix_ff, mid, top, win_ff[5], win_ff[4], win_ff[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   pixel_type red, green, blue;

   bbd_interp u_interp (
      .win   (win_ff),
      .top   (top),
      .mid   (mid),
      .bot   (s1_pix_ff),
      .site  (s1_site_ff),
      .red   (red),
      .green (green),
      .blue  (blue)
   );

   // output register
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_red        <= red;
         rsp_green      <= green;
         rsp_blue       <= blue;
         rsp_out_row    <= s1_orow_ff;
         rsp_out_col    <= s1_ocol_ff;
         rsp_frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/bbd_csr.sv =====
// ----------------------------------------------------------------------------
// bbd_csr
// APB register file: image width and height.
// ----------------------------------------------------------------------------
module bbd_csr
   import bbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_stb;
   reg_index_type    idx;

   assign idx        = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_stb) begin
         unique case (idx)
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_IMAGE_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.restart = wr_stb;

endmodule

// ===== rtl/core/bbd_line_mem.sv =====
// ----------------------------------------------------------------------------
// bbd_line_mem
// Two line stores side by side: {upper, middle} per column, registered read.
// ----------------------------------------------------------------------------
module bbd_line_mem
   import bbd_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [2*PIX_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [2*PIX_W-1:0] wr_data
);

   logic [2*PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/bbd_interp.sv =====
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear colour reconstruction of one centre pixel from its 3x3 strip.
// ----------------------------------------------------------------------------
module bbd_interp
   import bbd_pkg::*;
(
   input  window_type win,
   input  pixel_type  top,    // newest column
   input  pixel_type  mid,
   input  pixel_type  bot,
   input  site_type   site,
   output pixel_type  red,
   output pixel_type  green,
   output pixel_type  blue
);

   logic [PIX_W+1:0] diag_sum, cross_sum;
   logic [PIX_W:0]   horiz_sum, vert_sum;
   pixel_type        diag, cross_mean, horiz, vert, centre;

   // win: 0 top/1 mid/2 bot of column c-2, 3/4/5 of column c-1
   assign diag_sum  = 10'(win[0]) + 10'(top) + 10'(win[2]) + 10'(bot);
   assign cross_sum = 10'(win[3]) + 10'(win[1]) + 10'(mid) + 10'(win[5]);
   assign horiz_sum = 9'(win[1]) + 9'(mid);
   assign vert_sum  = 9'(win[3]) + 9'(win[5]);

   assign diag       = diag_sum[PIX_W+1:2];
   assign cross_mean = cross_sum[PIX_W+1:2];
   assign horiz      = horiz_sum[PIX_W:1];
   assign vert       = vert_sum[PIX_W:1];
   assign centre     = win[4];

   always_comb begin
      unique case ({site.odd_row, site.odd_col})
         2'b00: begin            // blue site
            red = diag;  green = cross_mean;  blue = centre;
         end
         2'b11: begin            // red site
            red = centre; green = cross_mean; blue = diag;
         end
         2'b01: begin            // green on a blue row
            red = vert;  green = centre; blue = horiz;
         end
         default: begin          // green on a red row
            red = horiz; green = centre; blue = vert;
         end
      endcase
   end

endmodule

// ===== rtl/core/bbd_checker.sv =====
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the demosaic, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker
   import bbd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_red,
   input logic [PIX_W-1:0] rsp_green,
   input logic [PIX_W-1:0] rsp_blue,
   input logic [POS_W-1:0] rsp_out_row,
   input logic [POS_W-1:0] rsp_out_col,
   input logic             rsp_frame_last
);

   // results come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_red, rsp_green, rsp_blue,
                                          rsp_out_row, rsp_out_col, rsp_frame_last}))
      else $error("result changed while stalled");

   // a fresh result follows the sample transfer that caused it, via the line store read and stage 1
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching sample transfer");

   // border pixels never come out
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row != '0) && (rsp_out_col != '0))
      else $error("border pixel on the result channel");

endmodule

bind bayer_bggr_bilinear_demosaic_top bbd_checker u_bbd_checker (.*);
